// File: rtl/core/rate_timed_round_robin_poller_macros.svh
// Assertion helpers for the poller RTL.
// They expect clk and rst_n in scope.
`ifndef RATE_TIMED_ROUND_ROBIN_POLLER_MACROS_SVH
`define RATE_TIMED_ROUND_ROBIN_POLLER_MACROS_SVH

// Property holds in the same cycle.
`define RTRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RTRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rtrr_pkg.sv
package rtrr_pkg;

  localparam int NUM_CH      = 8;
  localparam int CH_W        = 3;
  localparam int IVL_W       = 16;
  localparam int CMD_W       = 14;
  localparam int SLOT_DIVIDE = 9;
  localparam int SLOT_W      = (SLOT_DIVIDE > 1) ? $clog2(SLOT_DIVIDE) : 1;

  // register indexes, one interval register per channel
  localparam logic [CH_W-1:0] REG_IMU      = CH_W'(0);
  localparam logic [CH_W-1:0] REG_ALTITUDE = CH_W'(1);
  localparam logic [CH_W-1:0] REG_GPS      = CH_W'(2);
  localparam logic [CH_W-1:0] REG_MOTOR    = CH_W'(3);
  localparam logic [CH_W-1:0] REG_STATUS   = CH_W'(4);
  localparam logic [CH_W-1:0] REG_ANALOG   = CH_W'(5);
  localparam logic [CH_W-1:0] REG_POSE     = CH_W'(6);
  localparam logic [CH_W-1:0] REG_ESC      = CH_W'(7);

  localparam logic [CMD_W-1:0] CMD_IMU      = CMD_W'(102);
  localparam logic [CMD_W-1:0] CMD_ALTITUDE = CMD_W'(109);
  localparam logic [CMD_W-1:0] CMD_GPS      = CMD_W'(106);
  localparam logic [CMD_W-1:0] CMD_MOTOR    = CMD_W'(104);
  localparam logic [CMD_W-1:0] CMD_STATUS   = CMD_W'(14'h2000);
  localparam logic [CMD_W-1:0] CMD_ANALOG   = CMD_W'(14'h2002);
  localparam logic [CMD_W-1:0] CMD_POSE     = CMD_W'(14'h2220);
  localparam logic [CMD_W-1:0] CMD_ESC      = CMD_W'(14'h2041);

  typedef struct packed {
    logic              issue;
    logic [CH_W-1:0]   chan;
    logic [NUM_CH-1:0] mask;
    logic [CH_W-1:0]   ptr;
  } pick_res_t;

  function automatic logic [IVL_W-1:0] ivl_reset(input logic [CH_W-1:0] idx);
    logic [IVL_W-1:0] v;
    case (idx)
      REG_IMU:      v = IVL_W'(20);
      REG_ALTITUDE: v = IVL_W'(100);
      REG_GPS:      v = IVL_W'(200);
      REG_MOTOR:    v = IVL_W'(50);
      REG_STATUS:   v = IVL_W'(200);
      REG_ANALOG:   v = IVL_W'(500);
      REG_POSE:     v = IVL_W'(20);
      REG_ESC:      v = IVL_W'(50);
      default:      v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] cmd_of(input logic [CH_W-1:0] ch);
    logic [CMD_W-1:0] v;
    case (ch)
      REG_IMU:      v = CMD_IMU;
      REG_ALTITUDE: v = CMD_ALTITUDE;
      REG_GPS:      v = CMD_GPS;
      REG_MOTOR:    v = CMD_MOTOR;
      REG_STATUS:   v = CMD_STATUS;
      REG_ANALOG:   v = CMD_ANALOG;
      REG_POSE:     v = CMD_POSE;
      REG_ESC:      v = CMD_ESC;
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/rtrr_pick.sv
module rtrr_pick (
  input  logic                        slot,
  input  logic [rtrr_pkg::NUM_CH-1:0] mask,
  input  logic [rtrr_pkg::CH_W-1:0]   ptr,
  output rtrr_pkg::pick_res_t         res
);
  import rtrr_pkg::*;

  logic [NUM_CH-1:0] cleared;
  logic [CH_W-1:0]   cand;
  logic              found;

  always_comb begin
    res.issue = slot && mask[ptr];
    res.chan  = ptr;
    cleared   = mask & ~(NUM_CH'(1) << ptr);
    res.mask  = res.issue ? cleared : mask;
    res.ptr   = ptr;
    found     = 1'b0;
    cand      = ptr;
    // round-robin search starting at the channel just served
    for (int k = 0; k < NUM_CH; k++) begin
      cand = ptr + CH_W'(k);
      if (res.issue && !found && cleared[cand]) begin
        found   = 1'b1;
        res.ptr = cand;
      end
    end
  end

endmodule

// File: rtl/core/rate_timed_round_robin_poller.sv
// Rate-timed round-robin poller, eight request channels.
// Input channel: in_valid/in_stall with in_tick; each accepted item with
// in_tick high is one loop tick, an item with in_tick low changes nothing.
// Every tick advances each enabled channel's phase; a channel goes pending
// when its phase completes its interval. Every SLOT_DIVIDE-th tick the
// channel under the turn pointer is served if pending, giving one result
// item (out_request_channel, out_command_code); otherwise no result.
// Config: cfg_we writes cfg_data into interval register cfg_index (0
// disables that channel). Write only while idle.
// Path: an accepted tick waits in the input register, then one pass of logic
// feeds its result into the output register once the output can advance.
// Throughput: one item per cycle while no result waits on out_stall, set by
// the single pass through the per-channel phase compare and 8-way pointer search.
// Reset (rst_n low, synchronous): intervals take their defaults, phases,
// slot counter, pending mask and pointer clear, no item is held.
// When out_stall holds a waiting result, one more item can enter the input
// register; after that in_stall rises until the result is taken.
`include "rate_timed_round_robin_poller_macros.svh"

module rate_timed_round_robin_poller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_tick,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rtrr_pkg::CH_W-1:0]    out_request_channel,
  output logic [rtrr_pkg::CMD_W-1:0]   out_command_code,
  input  logic                         cfg_we,
  input  logic [rtrr_pkg::CH_W-1:0]    cfg_index,
  input  logic [rtrr_pkg::IVL_W-1:0]   cfg_data
);
  import rtrr_pkg::*;

  logic [IVL_W-1:0]  interval_r [NUM_CH];
  logic [IVL_W-1:0]  phase_r    [NUM_CH];
  logic [IVL_W-1:0]  phase_nxt  [NUM_CH];
  logic [IVL_W:0]    phase_inc  [NUM_CH];
  logic [NUM_CH-1:0] pend_r;
  logic [NUM_CH-1:0] pend_set;
  logic [CH_W-1:0]   ptr_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [SLOT_W:0]   slot_inc;
  logic              slot_hit;

  logic              s1_valid_r;
  logic              s1_tick_r;
  logic              out_valid_r;
  logic [CH_W-1:0]   out_channel_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic              advance;
  logic              go;
  pick_res_t         pick;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign go       = s1_valid_r && s1_tick_r && advance;

  assign out_valid           = out_valid_r;
  assign out_request_channel = out_channel_r;
  assign out_command_code    = out_cmd_r;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      phase_inc[c] = {1'b0, phase_r[c]} + (IVL_W+1)'(1);
      pend_set[c]  = 1'b0;
      if (interval_r[c] == '0) begin
        phase_nxt[c] = '0;
      end else if (phase_inc[c] >= {1'b0, interval_r[c]}) begin
        phase_nxt[c] = '0;
        pend_set[c]  = 1'b1;
      end else begin
        phase_nxt[c] = phase_inc[c][IVL_W-1:0];
      end
    end
    slot_inc = {1'b0, slot_r} + (SLOT_W+1)'(1);
    slot_hit = (slot_inc >= (SLOT_W+1)'(SLOT_DIVIDE));
    slot_nxt = slot_hit ? '0 : slot_inc[SLOT_W-1:0];
  end

  rtrr_pick u_pick (
    .slot (slot_hit),
    .mask (pend_r | pend_set),
    .ptr  (ptr_r),
    .res  (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        interval_r[c] <= ivl_reset(CH_W'(c));
        phase_r[c]    <= '0;
      end
      pend_r      <= '0;
      ptr_r       <= '0;
      slot_r      <= '0;
      s1_valid_r  <= 1'b0;
      s1_tick_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        interval_r[cfg_index] <= cfg_data;
      end
      if (go) begin
        for (int c = 0; c < NUM_CH; c++) begin
          phase_r[c] <= phase_nxt[c];
        end
        pend_r <= pick.mask;
        ptr_r  <= pick.ptr;
        slot_r <= slot_nxt;
      end
      if (advance) begin
        out_valid_r <= go && pick.issue;
      end
      // an empty input register takes an item even while the output waits
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        s1_tick_r  <= in_tick;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (go && pick.issue) begin
      out_channel_r <= pick.chan;
      out_cmd_r     <= cmd_of(pick.chan);
    end
  end

  `RTRR_ASSERT(a_slot_range, slot_r < SLOT_W'(SLOT_DIVIDE), "slot counter out of range")
  `RTRR_ASSERT(a_stall_needs_item, !in_stall || s1_valid_r, "stall with empty input stage")
  `RTRR_ASSERT(a_cmd_match, !out_valid_r || out_cmd_r == cmd_of(out_channel_r), "command mismatch")
  `RTRR_ASSERT_NEXT(a_served_cleared, go && pick.issue, !pend_r[out_channel_r], "served bit still pending")
  `RTRR_ASSERT_NEXT(a_ptr_on_pending, go && pick.issue && pick.mask != '0, pend_r[ptr_r], "pointer not on pending channel")

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtrr_pkg::*;

  localparam int LIMIT       = 100000;
  localparam int DRAIN_WAIT  = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 900;
  localparam int DIR_ROWS    = 19;

  localparam logic [NUM_CH-1:0][CMD_W-1:0] CMD_BY_CH = {
    CMD_ESC, CMD_POSE, CMD_ANALOG, CMD_STATUS, CMD_MOTOR, CMD_GPS, CMD_ALTITUDE, CMD_IMU
  };
  localparam logic [NUM_CH-1:0][IVL_W-1:0] IVL_DEFAULT = {
    IVL_W'(50), IVL_W'(20), IVL_W'(500), IVL_W'(200),
    IVL_W'(50), IVL_W'(200), IVL_W'(100), IVL_W'(20)
  };

  typedef struct packed {
    logic [CH_W-1:0]  chan;
    logic [CMD_W-1:0] cmd;
  } poll_req_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CH_W-1:0]  idx;
    logic [IVL_W-1:0] data;
    logic             tick;
    logic [7:0]       reps;
    logic             typed;
    poll_req_t        want;
  } dir_row_t;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic              in_tick   = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CH_W-1:0]   out_request_channel;
  logic [CMD_W-1:0]  out_command_code;
  logic              cfg_we    = 1'b0;
  logic [CH_W-1:0]   cfg_index = '0;
  logic [IVL_W-1:0]  cfg_data  = '0;

  // poller state as predicted
  logic [IVL_W-1:0]  ivl [NUM_CH];
  logic [IVL_W-1:0]  ch_phase [NUM_CH];
  int                slot_cnt;
  logic [NUM_CH-1:0] pend;
  logic [CH_W-1:0]   turn;

  poll_req_t predicted_reqs [$];
  dir_row_t  dir_tab [DIR_ROWS];

  int errors      = 0;
  int cycles      = 0;
  int n_items     = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  rate_timed_round_robin_poller dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_tick             (in_tick),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_request_channel (out_request_channel),
    .out_command_code    (out_command_code),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One tick through the poller; returns 1 when a request goes out.
  function automatic bit poll_step(input logic t, output poll_req_t r);
    logic [CH_W-1:0] c;
    logic [CH_W-1:0] cand;
    bit              slot;
    bit              found;
    r = '0;
    if (!t) return 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (ivl[i] == '0) begin
        ch_phase[i] = '0;
      end else if ({1'b0, ch_phase[i]} + 17'd1 >= {1'b0, ivl[i]}) begin
        ch_phase[i] = '0;
        pend[i] = 1'b1;
      end else begin
        ch_phase[i] = ch_phase[i] + 1'b1;
      end
    end
    slot = (slot_cnt + 1 >= SLOT_DIVIDE);
    slot_cnt = slot ? 0 : slot_cnt + 1;
    c = turn;
    if (!slot || !pend[c]) return 1'b0;
    r.chan = c;
    r.cmd = CMD_BY_CH[c];
    pend[c] = 1'b0;
    // round-robin search starts at the channel just served
    found = 1'b0;
    for (int k = 0; k < NUM_CH; k++) begin
      cand = c + CH_W'(k);
      if (!found && pend[cand]) begin
        turn = cand;
        found = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [IVL_W-1:0] rand_ivl();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return IVL_W'(1);
      3:       return '1;
      4, 5, 6: return IVL_W'($urandom_range(20, 2));
      7, 8:    return IVL_W'($urandom_range(120, 21));
      default: return IVL_W'($urandom());
    endcase
  endfunction

  function automatic dir_row_t cfg_row(input logic [CH_W-1:0] idx, input logic [IVL_W-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic dir_row_t tick_row(input logic t, input int reps);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.tick = t;
    r.reps = 8'(reps);
    return r;
  endfunction

  function automatic dir_row_t hit_row(input logic [CH_W-1:0] chan, input logic [CMD_W-1:0] cmd);
    dir_row_t r;
    r = tick_row(1'b1, 1);
    r.typed = 1'b1;
    r.want.chan = chan;
    r.want.cmd = cmd;
    return r;
  endfunction

  task automatic offer_tick(input logic t, input bit typed, input poll_req_t want);
    poll_req_t r;
    bit        got;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= t;
    do @(posedge clk); while (in_stall);
    got = poll_step(t, r);
    if (typed) begin
      predicted_reqs = {predicted_reqs, want};
    end else if (got) begin
      predicted_reqs = {predicted_reqs, r};
    end
    n_items++;
  endtask

  task automatic write_ivl(input logic [CH_W-1:0] idx, input logic [IVL_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    ivl[idx] = data;
    @(posedge clk);
  endtask

  // drain outstanding requests, then idle with in_valid low to clear the pipe
  task automatic settle();
    in_valid <= 1'b0;
    while (predicted_reqs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic check_req();
    poll_req_t w;
    if (predicted_reqs.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual chan %0d cmd 0x%0h",
               $time, out_request_channel, out_command_code);
      errors++;
      return;
    end
    w = predicted_reqs.pop_front();
    if (out_request_channel !== w.chan) begin
      $display("%0t: request_channel expected %0d actual %0d",
               $time, w.chan, out_request_channel);
      errors++;
    end
    if (out_command_code !== w.cmd) begin
      $display("%0t: command_code expected 0x%0h actual 0x%0h",
               $time, w.cmd, out_command_code);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_req();
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    bit busy;
    int n;
    logic t;
    busy = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      ivl[i] = IVL_DEFAULT[i];
      ch_phase[i] = '0;
    end
    slot_cnt = 0;
    pend = '0;
    turn = '0;

    // channel 0 runs every tick, channel 7 at its longest interval; then channel 0 is disabled with its bit
    // still pending, and channel 7 gets its interval cut below its phase
    dir_tab = '{
      cfg_row(REG_IMU, IVL_W'(1)),
      cfg_row(REG_ALTITUDE, '0),
      cfg_row(REG_GPS, '0),
      cfg_row(REG_MOTOR, '0),
      cfg_row(REG_STATUS, '0),
      cfg_row(REG_ANALOG, '0),
      cfg_row(REG_POSE, '0),
      cfg_row(REG_ESC, '1),
      tick_row(1'b0, 1),
      tick_row(1'b1, 8),
      hit_row(REG_IMU, CMD_IMU),
      tick_row(1'b1, 3),
      cfg_row(REG_IMU, '0),
      cfg_row(REG_MOTOR, IVL_W'(2)),
      cfg_row(REG_ESC, IVL_W'(3)),
      tick_row(1'b0, 1),
      tick_row(1'b1, 5),
      hit_row(REG_IMU, CMD_IMU),
      tick_row(1'b1, 4)
    };

    tx_idle_pct = 15;
    rx_idle_pct <= 67;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (busy) settle();
        busy = 1'b0;
        write_ivl(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        cfg_we <= 1'b0;
        busy = 1'b1;
        for (int k = 0; k < dir_tab[i].reps; k++)
          offer_tick(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    while (n_items < ITEM_TARGET) begin
      if (n_items < ITEM_TARGET / 3) begin
        tx_idle_pct = 15;
        rx_idle_pct <= 67;
      end else if (n_items < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 67;
        rx_idle_pct <= 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
      end
      settle();
      for (int i = 0; i < NUM_CH; i++) write_ivl(CH_W'(i), rand_ivl());
      cfg_we <= 1'b0;
      n = $urandom_range(120, 30);
      repeat (n) begin
        t = ($urandom_range(9) != 0);
        offer_tick(t, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
